// File: sv/fresnel_reflectance_unit_defines.svh
// ----------------------------------------------------------------------------
// Fresnel reflectance unit - assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_REFLECTANCE_UNIT_DEFINES_SVH
`define FRESNEL_REFLECTANCE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define FRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// holds in the cycle after a reset cycle
`define FRL_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

// File: sv/frl_pkg.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Item types, stage control and fixed-point constants.
// ----------------------------------------------------------------------------
package frl_pkg;

    typedef struct packed {
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic        [15:0] refr_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_reflect;
    } t_out_item;

    // pipeline control for the square-root and divider units
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    // geometry carried alongside the arithmetic units
    typedef struct packed {
        logic [30:0] cos_i;
        logic        is_inner;
        logic [15:0] eta;
    } t_geo;

    typedef struct packed {
        t_geo geo;
        logic tir;
    } t_geo_tir;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [61:0] ONE_Q60   = 62'h1000_0000_0000_0000;
    localparam logic [15:0] ETA_ONE   = 16'd4096;
    localparam logic [15:0] REFL_ONE  = 16'd32768;
    localparam logic [62:0] ROUND_Q45 = 63'h0000_1000_0000_0000;

endpackage

// File: sv/frl_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit recurrence, one root bit per register stage.
// ----------------------------------------------------------------------------
module frl_sqrt
    import frl_pkg::*;
#(
    parameter int RAD_W  = 62,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pipe_ctl            i_ctl,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    logic [RAD_W-1:0]  n_rad  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [SIDE_W-1:0] n_side [ROOT_W];
    logic [ROOT_W-1:0] n_vld;

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [REM_W-1:0]  rem2;
            logic [REM_W-1:0]  trial;
            logic              take;
            if (k == 0) begin
                rad_in    = i_rad;
                rem_in    = '0;
                root_in   = '0;
                n_side[k] = i_side;
                n_vld[k]  = i_ctl.valid;
            end else begin
                rad_in    = r_rad[k-1];
                rem_in    = r_rem[k-1];
                root_in   = r_root[k-1];
                n_side[k] = r_side[k-1];
                n_vld[k]  = r_vld[k-1];
            end
            // bring down the next two radicand bits, try root*4+1
            rem2      = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            take      = (rem2 >= trial);
            n_rem[k]  = take ? (rem2 - trial) : rem2;
            n_root[k] = {root_in[ROOT_W-2:0], take};
            n_rad[k]  = rad_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= n_vld;
        end
        if (i_ctl.en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= n_side;
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// File: sv/frl_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The quotient
// must fit Q_W bits; otherwise the result is meaningless.
// ----------------------------------------------------------------------------
module frl_div
    import frl_pkg::*;
#(
    parameter int N_W    = 62,
    parameter int D_W    = 32,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic [N_W-1:0]    i_num,
    input  logic [D_W-1:0]    i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CMP_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [CMP_W-1:0]  r_rem  [Q_W];
    logic [D_W-1:0]    r_den  [Q_W];
    logic [Q_W-1:0]    r_quot [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic [Q_W-1:0]    r_vld;

    logic [CMP_W-1:0]  n_rem  [Q_W];
    logic [D_W-1:0]    n_den  [Q_W];
    logic [Q_W-1:0]    n_quot [Q_W];
    logic [SIDE_W-1:0] n_side [Q_W];
    logic [Q_W-1:0]    n_vld;

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            logic [CMP_W-1:0] rem_in;
            logic [Q_W-1:0]   quot_in;
            logic [CMP_W-1:0] dsh;
            logic             take;
            if (k == 0) begin
                rem_in    = CMP_W'(i_num);
                quot_in   = '0;
                n_den[k]  = i_den;
                n_side[k] = i_side;
                n_vld[k]  = i_ctl.valid;
            end else begin
                rem_in    = r_rem[k-1];
                quot_in   = r_quot[k-1];
                n_den[k]  = r_den[k-1];
                n_side[k] = r_side[k-1];
                n_vld[k]  = r_vld[k-1];
            end
            // most significant quotient bit first
            dsh       = CMP_W'(n_den[k]) << (Q_W - 1 - k);
            take      = (rem_in >= dsh);
            n_rem[k]  = take ? (rem_in - dsh) : rem_in;
            n_quot[k] = {quot_in[Q_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= n_vld;
        end
        if (i_ctl.en) begin
            r_rem  <= n_rem;
            r_den  <= n_den;
            r_quot <= n_quot;
            r_side <= n_side;
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// File: sv/fresnel_reflectance_unit.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance unit
// Unpolarized Fresnel reflectance from incident direction, normal and index.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | to unit   | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | from unit | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//
//  One item enters per cycle while the output is not stalled; the items run
//  through two square roots and two dividers, each producing one bit per stage.
//  Reset is synchronous and clears only the stage valid bits.
//  A stall on a valid output freezes every stage at once; o_in_stall follows
//  it in the same cycle, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "fresnel_reflectance_unit_defines.svh"

module fresnel_reflectance_unit
    import frl_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int SH_L   = (2 * VEC_FRAC_BITS < 30) ? 30 - 2 * VEC_FRAC_BITS : 0;
    localparam int SH_R   = (2 * VEC_FRAC_BITS >= 30) ? 2 * VEC_FRAC_BITS - 30 : 0;
    localparam int WIDE_W = 33 + SH_L;

    function automatic logic [4:0] norm_shift(input logic [47:0] den);
        logic [4:0] sh;
        sh = '0;
        for (int i = 32; i < 48; i++) begin
            if (den[i]) begin
                sh = 5'(i - 31);
            end
        end
        return sh;
    endfunction

    logic       en;
    t_pipe_ctl  ctl;

    logic       r_out_valid;
    t_out_item  r_out_item;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---- stage 1: component products ----
    logic               r1_v;
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic [15:0]        r1_eta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
        if (en) begin
            r1_px  <= i_in_item.incident_x * i_in_item.normal_x;
            r1_py  <= i_in_item.incident_y * i_in_item.normal_y;
            r1_pz  <= i_in_item.incident_z * i_in_item.normal_z;
            // zero index means the smallest step
            r1_eta <= (i_in_item.refr_index == '0) ? 16'd1 : i_in_item.refr_index;
        end
    end

    // ---- stage 2: dot product ----
    logic               r2_v;
    logic signed [33:0] r2_dot;
    logic [15:0]        r2_eta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_dot <= 34'(r1_px) + 34'(r1_py) + 34'(r1_pz);
            r2_eta <= r1_eta;
        end
    end

    // ---- stage 3: magnitude to Q.30, clamp ----
    logic [32:0]       mag;
    logic [WIDE_W-1:0] wide;
    logic              r3_v;
    t_geo              r3_geo;

    always_comb begin
        mag  = r2_dot[33] ? 33'(-r2_dot) : 33'(r2_dot);
        wide = (WIDE_W'(mag) << SH_L) >> SH_R;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_geo.cos_i    <= (wide > WIDE_W'(ONE_Q30)) ? ONE_Q30 : wide[30:0];
            r3_geo.is_inner <= (r2_dot > 34'sd0);
            r3_geo.eta      <= r2_eta;
        end
    end

    // ---- stage 4: cos squared ----
    logic        r4_v;
    logic [61:0] r4_cc;
    t_geo        r4_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
        if (en) begin
            r4_cc  <= 62'(r3_geo.cos_i) * 62'(r3_geo.cos_i);
            r4_geo <= r3_geo;
        end
    end

    assign ctl.en    = en;
    assign ctl.valid = r4_v;

    // ---- incident sine ----
    logic                 sq1_v;
    logic [30:0]          sin_i;
    logic [$bits(t_geo)-1:0] sq1_side;
    t_geo                 geo5;

    frl_sqrt #(.RAD_W(62), .SIDE_W($bits(t_geo))) u_sqrt_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_rad   (ONE_Q60 - r4_cc),
        .i_side  (r4_geo),
        .o_valid (sq1_v),
        .o_root  (sin_i),
        .o_side  (sq1_side)
    );

    assign geo5 = t_geo'(sq1_side);

    // ---- stage 5: Snell numerator ----
    logic        r5_v;
    logic [46:0] r5_prod;
    logic [15:0] r5_etat;
    t_geo        r5_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= sq1_v;
        end
        if (en) begin
            r5_prod <= 47'(sin_i) * 47'(geo5.is_inner ? geo5.eta : ETA_ONE);
            r5_etat <= geo5.is_inner ? ETA_ONE : geo5.eta;
            r5_geo  <= geo5;
        end
    end

    t_pipe_ctl ctl5;
    t_geo_tir  side5;

    assign ctl5.en    = en;
    assign ctl5.valid = r5_v;
    assign side5.geo  = r5_geo;
    // transmitted sine reaches one
    assign side5.tir  = (r5_prod >= {1'b0, r5_etat, 30'b0});

    logic                        dv1_v;
    logic [29:0]                 sin_t;
    logic [$bits(t_geo_tir)-1:0] dv1_side;
    t_geo_tir                    gt6;

    frl_div #(.N_W(47), .D_W(16), .Q_W(30), .SIDE_W($bits(t_geo_tir))) u_div_snell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl5),
        .i_num   (r5_prod),
        .i_den   (r5_etat),
        .i_side  (side5),
        .o_valid (dv1_v),
        .o_quot  (sin_t),
        .o_side  (dv1_side)
    );

    assign gt6 = t_geo_tir'(dv1_side);

    // ---- stage 6: sin_t squared ----
    logic        r6_v;
    logic [59:0] r6_ss;
    t_geo_tir    r6_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= dv1_v;
        end
        if (en) begin
            r6_ss <= 60'(sin_t) * 60'(sin_t);
            r6_gt <= gt6;
        end
    end

    t_pipe_ctl ctl6;

    assign ctl6.en    = en;
    assign ctl6.valid = r6_v;

    logic                        sq2_v;
    logic [30:0]                 cos_t;
    logic [$bits(t_geo_tir)-1:0] sq2_side;
    t_geo_tir                    gt7;

    frl_sqrt #(.RAD_W(62), .SIDE_W($bits(t_geo_tir))) u_sqrt_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl6),
        .i_rad   (ONE_Q60 - 62'(r6_ss)),
        .i_side  (r6_gt),
        .o_valid (sq2_v),
        .o_root  (cos_t),
        .o_side  (sq2_side)
    );

    assign gt7 = t_geo_tir'(sq2_side);

    // ---- stage 7: the four index products ----
    logic [15:0] etai7, etat7;
    logic        r7_v;
    logic        r7_tir;
    logic [46:0] r7_xs, r7_ys, r7_xp, r7_yp;

    assign etai7 = gt7.geo.is_inner ? gt7.geo.eta : ETA_ONE;
    assign etat7 = gt7.geo.is_inner ? ETA_ONE : gt7.geo.eta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= sq2_v;
        end
        if (en) begin
            r7_xs  <= 47'(etat7) * 47'(gt7.geo.cos_i);
            r7_ys  <= 47'(etai7) * 47'(cos_t);
            r7_xp  <= 47'(etai7) * 47'(gt7.geo.cos_i);
            r7_yp  <= 47'(etat7) * 47'(cos_t);
            r7_tir <= gt7.tir;
        end
    end

    // ---- stage 8: difference, sum, normalize amount ----
    logic [47:0] dens8, denp8;
    logic        r8_v;
    logic        r8_tir;
    logic [46:0] r8_nums, r8_nump;
    logic [47:0] r8_dens, r8_denp;
    logic [4:0]  r8_shs, r8_shp;

    assign dens8 = 48'(r7_xs) + 48'(r7_ys);
    assign denp8 = 48'(r7_xp) + 48'(r7_yp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
        if (en) begin
            r8_nums <= (r7_xs > r7_ys) ? (r7_xs - r7_ys) : (r7_ys - r7_xs);
            r8_nump <= (r7_xp > r7_yp) ? (r7_xp - r7_yp) : (r7_yp - r7_xp);
            r8_dens <= dens8;
            r8_denp <= denp8;
            r8_shs  <= norm_shift(dens8);
            r8_shp  <= norm_shift(denp8);
            r8_tir  <= r7_tir;
        end
    end

    // ---- stage 9: shift denominators below 2^32 ----
    logic        r9_v;
    logic        r9_tir;
    logic [31:0] r9_nums, r9_nump, r9_dens, r9_denp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
        if (en) begin
            r9_nums <= 32'(r8_nums >> r8_shs);
            r9_nump <= 32'(r8_nump >> r8_shp);
            r9_dens <= 32'(r8_dens >> r8_shs);
            r9_denp <= 32'(r8_denp >> r8_shp);
            r9_tir  <= r8_tir;
        end
    end

    t_pipe_ctl ctl9;

    assign ctl9.en    = en;
    assign ctl9.valid = r9_v;

    logic        dvs_v, dvp_v;
    logic [30:0] r_s, r_p;
    logic        tir_s, tir_p;

    frl_div #(.N_W(62), .D_W(32), .Q_W(31), .SIDE_W(1)) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl9),
        .i_num   ({r9_nums, 30'b0}),
        .i_den   (r9_dens),
        .i_side  (r9_tir),
        .o_valid (dvs_v),
        .o_quot  (r_s),
        .o_side  (tir_s)
    );

    frl_div #(.N_W(62), .D_W(32), .Q_W(31), .SIDE_W(1)) u_div_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl9),
        .i_num   ({r9_nump, 30'b0}),
        .i_den   (r9_denp),
        .i_side  (r9_tir),
        .o_valid (dvp_v),
        .o_quot  (r_p),
        .o_side  (tir_p)
    );

    // ---- stage 10: squared ratios ----
    logic        r10_v;
    logic        r10_tir;
    logic [61:0] r10_ss, r10_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= dvs_v & dvp_v;
        end
        if (en) begin
            r10_ss  <= 62'(r_s) * 62'(r_s);
            r10_pp  <= 62'(r_p) * 62'(r_p);
            r10_tir <= tir_s | tir_p;
        end
    end

    // ---- stage 11: average, round to Q1.15, saturate ----
    logic [62:0] kr_half;
    logic [62:0] kr_rnd;
    logic [17:0] kr_q15;
    logic [15:0] kr_sat;

    always_comb begin
        kr_half = (63'(r10_ss) + 63'(r10_pp)) >> 1;
        kr_rnd  = kr_half + ROUND_Q45;
        kr_q15  = kr_rnd[62:45];
        kr_sat  = (kr_q15 > 18'(REFL_ONE)) ? REFL_ONE : kr_q15[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r10_v;
        end
        if (en) begin
            r_out_item.reflectance   <= r10_tir ? REFL_ONE : kr_sat;
            r_out_item.total_reflect <= r10_tir;
        end
    end

    `FRL_ASSERT_NOW(a_tir_full, o_out_valid && o_out_item.total_reflect, o_out_item.reflectance == REFL_ONE, "total reflection without full reflectance")
    `FRL_ASSERT_NOW(a_refl_range, o_out_valid, o_out_item.reflectance <= REFL_ONE, "reflectance above one")
    `FRL_ASSERT_AFTER_RESET(a_reset_empty, !o_out_valid, "output valid right after reset")

endmodule
